// ===== rtl/cpf_pkg.sv =====
// Shared types and constants for the CPF item extractor.
`default_nettype none
package cpf_pkg;

  // Result status codes
  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_TOO_SHORT = 3'd4;

  // Parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_ITEM   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  localparam logic [2:0]  HDR_LAST_IDX  = 3'd7;  // index of final header byte
  localparam logic [2:0]  ITEM_LAST_IDX = 3'd3;  // index of final item-header byte
  localparam logic [1:0]  SEQ_BYTES     = 2'd2;
  localparam logic [15:0] SEQ_LEN       = 16'd2;

  // Config register indexes and reset values
  localparam logic CFG_WANTED_TYPE = 1'b0;
  localparam logic CFG_STRIP_SEQ   = 1'b1;
  localparam logic [15:0] WANTED_TYPE_RST = 16'd178;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/cpf_parse.sv =====
// CPF frame walker: per-byte state update and result generation.
`default_nettype none
module cpf_parse
  import cpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  input  wire logic        end_in,
  input  wire logic [15:0] wanted_type,
  input  wire logic        strip_seq,
  output res_t             res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] items_r, items_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [1:0]  skip_r, skip_nxt;
  logic        done_r, done_nxt;
  logic [15:0] len;
  logic [15:0] typ;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    items_nxt = items_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    skip_nxt  = skip_r;
    done_nxt  = done_r;
    res       = '0;
    typ       = shift_nxt[15:0];
    len       = shift_nxt[31:16];

    if (!done_r) begin
      case (phase_r)
        PH_ITEM: begin
          shift_nxt = {byte_in, shift_r[31:8]};
          typ       = shift_nxt[15:0];
          len       = shift_nxt[31:16];
          if (cnt_r == ITEM_LAST_IDX) begin
            cnt_nxt = '0;
            if (typ == wanted_type) begin
              if (strip_seq && (len < SEQ_LEN)) begin
                res.vld = 1'b1; res.status = ST_TOO_SHORT; res.last = 1'b1;
                done_nxt = 1'b1;
              end else if (len == (strip_seq ? SEQ_LEN : 16'd0)) begin
                res.vld = 1'b1; res.status = ST_EMPTY; res.last = 1'b1;
                done_nxt = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
                rem_nxt   = len;
                skip_nxt  = strip_seq ? SEQ_BYTES : 2'd0;
              end
            end else if (len == 16'd0) begin
              items_nxt = items_r - 16'd1;
              if (items_nxt == 16'd0) begin
                res.vld = 1'b1; res.status = ST_NOT_FOUND; res.last = 1'b1;
                done_nxt = 1'b1;
              end
            end else begin
              phase_nxt = PH_SKIP;
              rem_nxt   = len;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt == 16'd0) begin
            items_nxt = items_r - 16'd1;
            if (items_nxt == 16'd0) begin
              res.vld = 1'b1; res.status = ST_NOT_FOUND; res.last = 1'b1;
              done_nxt = 1'b1;
            end else begin
              phase_nxt = PH_ITEM;
              cnt_nxt   = '0;
            end
          end
        end
        PH_DATA: begin
          rem_nxt = rem_r - 16'd1;
          if (skip_r != 2'd0) begin
            skip_nxt = skip_r - 2'd1;
          end else begin
            res.vld    = 1'b1;
            res.data   = byte_in;
            res.status = ST_DATA;
            if (rem_nxt == 16'd0) begin
              res.last = 1'b1;
              done_nxt = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          shift_nxt = {byte_in, shift_r[31:8]};
          if (cnt_r == HDR_LAST_IDX) begin
            items_nxt = shift_nxt[31:16];
            cnt_nxt   = '0;
            if (items_nxt == 16'd0) begin
              res.vld = 1'b1; res.status = ST_NOT_FOUND; res.last = 1'b1;
              done_nxt = 1'b1;
            end else begin
              phase_nxt = PH_ITEM;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      endcase
    end

    // frame end: truncated unless the final result already went out
    if (end_in) begin
      if (!done_nxt) begin
        res.vld    = 1'b1;
        res.data   = '0;
        res.status = ST_TRUNCATED;
        res.last   = 1'b1;
      end
      phase_nxt = PH_HEADER;
      cnt_nxt   = '0;
      items_nxt = '0;
      shift_nxt = '0;
      rem_nxt   = '0;
      skip_nxt  = '0;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      items_r <= '0;
      shift_r <= '0;
      rem_r   <= '0;
      skip_r  <= '0;
      done_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      items_r <= items_nxt;
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
      skip_r  <= skip_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpf_res_buf.sv =====
// Two-entry result buffer between the parser and the output channel.
`default_nettype none
module cpf_res_buf
  import cpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  res_t      wr_res,
  output logic      full,
  output logic      rd_vld,
  input  wire logic rd_en,
  output res_t      rd_res
);

  res_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_rd;

  assign full   = (cnt_r == 2'd2);
  assign rd_vld = (cnt_r != 2'd0);
  assign rd_res = mem_r[rd_ptr_r];
  assign do_rd  = rd_en && rd_vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!wr_en && do_rd) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpf_item_extractor.sv =====
// A word taken on in_* sits in the input register until the result buffer has room, is then
// parsed, and its result (if any) is written into the result buffer and shown on out_*.
// Throughput: one frame byte per cycle; in_tready drops only while a word is held in the
// input register and the two-entry result buffer is full after output stalls.
// Reset (rst_n low, synchronous): parser back to header phase, buffers empty,
// wanted_type = 178, strip_sequence = 0.
`default_nettype none
module cpf_item_extractor
  import cpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  wire logic        in_tlast,   // frame_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] payload_byte
  output logic [2:0]       out_tuser,  // [2:0] status
  output logic             out_tlast,  // last
  // config writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,  // 0 wanted_type, 1 strip_sequence
  input  wire logic [15:0] cfg_data
);

  // config registers
  logic [15:0] wanted_type_r;
  logic        strip_seq_r;

  // input register stage
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;

  logic        buf_full;
  logic        adv;       // input register word is parsed this cycle
  res_t        res;
  res_t        rd_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r <= WANTED_TYPE_RST;
      strip_seq_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WANTED_TYPE: wanted_type_r <= cfg_data;
        CFG_STRIP_SEQ:   strip_seq_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Parse whenever the result buffer has room; every byte needs a slot since
  // whether it yields a result is only known after parsing.
  assign adv       = in_v_r && !buf_full;
  assign in_tready = !in_v_r || !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  cpf_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .byte_in     (in_byte_r),
    .end_in      (in_end_r),
    .wanted_type (wanted_type_r),
    .strip_seq   (strip_seq_r),
    .res         (res)
  );

  cpf_res_buf u_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (adv && res.vld),
    .wr_res (res),
    .full   (buf_full),
    .rd_vld (out_tvalid),
    .rd_en  (out_tready),
    .rd_res (rd_res)
  );

  assign out_tdata = rd_res.data;
  assign out_tuser = rd_res.status;
  assign out_tlast = rd_res.last;

`ifndef ASSERT_OFF
  // a held input word is not overwritten before it is parsed
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |=> (in_v_r && $stable(in_byte_r) && $stable(in_end_r)))
    else $error("input word lost before parse");

  // every non-data status closes the frame
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_DATA)) |-> out_tlast)
    else $error("status result without last");

  // non-data results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_DATA)) |-> (out_tdata == 8'd0))
    else $error("status result with nonzero payload");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= ST_TOO_SHORT))
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_cpf_item_extractor.sv =====
// Testbench for cpf_item_extractor: directed table plus random CPF frames, checked by a predictor.
`default_nettype none
module tb_cpf_item_extractor
  import cpf_pkg::*;
();

  // Run limits. Slowest correct run is roughly 2000 words times
  // (sender gap + receiver stall + pipeline) plus the long hold-off,
  // so CYCLE_LIMIT leaves plenty of margin.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;     // covers words still in the input register and result buffer; pad it well
  localparam int PHASE_WORDS   = 195;   // minimum frame bytes per config setting
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_AT       = 150;   // result count that triggers the long hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_GAP       = 8;

  // One result word as it leaves the block
  typedef struct packed {
    logic [7:0] payload;
    logic [2:0] status;
    logic       last;
  } extract_result_t;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    ROW_MODEL,   // let the predictor decide
    ROW_QUIET,   // no result for this word
    ROW_RESULT   // result typed into the table
  } row_check_e;

  typedef struct packed {
    logic [7:0]      frame_byte;
    logic            frame_end;
    row_check_e      check;
    extract_result_t want;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] frame_byte
  logic        in_tlast;   // frame_end
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] payload_byte
  logic [2:0]  out_tuser;  // [2:0] status
  logic        out_tlast;  // last
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  cpf_item_extractor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Parser predictor: its own copy of registers and frame state
  // ---------------------------------------------------------------
  logic [15:0] want_type;
  logic        strip_seq;

  logic [1:0]  prs_phase;
  logic [2:0]  hdr_idx;
  logic [15:0] items_left;
  logic [31:0] hdr_shift;
  logic [15:0] data_left;
  logic [1:0]  seq_left;
  logic        frame_closed;

  extract_result_t pending_results[$];
  int errors;
  int n_checked;
  bit burst_in;

  function automatic void clear_parser();
    prs_phase    = PH_HEADER;
    hdr_idx      = '0;
    items_left   = '0;
    hdr_shift    = '0;
    data_left    = '0;
    seq_left     = '0;
    frame_closed = 1'b0;
  endfunction

  // Advances the parser by one frame byte; returns 1 if a result comes out.
  function automatic bit parse_byte(input logic [7:0] b, input logic e,
                                    output extract_result_t r);
    bit          hit;
    logic [15:0] typ;
    logic [15:0] len;
    hit = 1'b0;
    r   = '{payload: 8'd0, status: ST_DATA, last: 1'b0};
    if (!frame_closed) begin
      case (prs_phase)
        PH_ITEM: begin
          hdr_shift = {b, hdr_shift[31:8]};
          if (hdr_idx == ITEM_LAST_IDX) begin
            typ     = hdr_shift[15:0];
            len     = hdr_shift[31:16];
            hdr_idx = '0;
            if (typ == want_type) begin
              if (strip_seq && len < SEQ_LEN) begin
                r.status = ST_TOO_SHORT; r.last = 1'b1; hit = 1'b1; frame_closed = 1'b1;
              end else if (len == (strip_seq ? SEQ_LEN : 16'd0)) begin
                r.status = ST_EMPTY; r.last = 1'b1; hit = 1'b1; frame_closed = 1'b1;
              end else begin
                prs_phase = PH_DATA;
                data_left = len;
                seq_left  = strip_seq ? SEQ_BYTES : 2'd0;
              end
            end else if (len == 16'd0) begin
              // zero-length foreign item: counts as walked right away
              items_left = items_left - 16'd1;
              if (items_left == 16'd0) begin
                r.status = ST_NOT_FOUND; r.last = 1'b1; hit = 1'b1; frame_closed = 1'b1;
              end
            end else begin
              prs_phase = PH_SKIP;
              data_left = len;
            end
          end else begin
            hdr_idx = hdr_idx + 3'd1;
          end
        end
        PH_SKIP: begin
          data_left = data_left - 16'd1;
          if (data_left == 16'd0) begin
            items_left = items_left - 16'd1;
            if (items_left == 16'd0) begin
              r.status = ST_NOT_FOUND; r.last = 1'b1; hit = 1'b1; frame_closed = 1'b1;
            end else begin
              prs_phase = PH_ITEM;
              hdr_idx   = '0;
            end
          end
        end
        PH_DATA: begin
          data_left = data_left - 16'd1;
          if (seq_left != 2'd0) begin
            seq_left = seq_left - 2'd1;
          end else begin
            r.payload = b; hit = 1'b1;
            if (data_left == 16'd0) begin
              r.last = 1'b1; frame_closed = 1'b1;
            end
          end
        end
        default: begin
          prs_phase = PH_HEADER;
          hdr_shift = {b, hdr_shift[31:8]};
          if (hdr_idx == HDR_LAST_IDX) begin
            // item count is the top half of the last four header bytes
            items_left = hdr_shift[31:16];
            hdr_idx    = '0;
            if (items_left == 16'd0) begin
              r.status = ST_NOT_FOUND; r.last = 1'b1; hit = 1'b1; frame_closed = 1'b1;
            end else begin
              prs_phase = PH_ITEM;
            end
          end else begin
            hdr_idx = hdr_idx + 3'd1;
          end
        end
      endcase
    end
    if (e) begin
      // frame ended before its final result: truncation replaces this word's result
      if (!frame_closed) begin
        r   = '{payload: 8'd0, status: ST_TRUNCATED, last: 1'b1};
        hit = 1'b1;
      end
      clear_parser();
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------
  // Directed table: short error frame, zero item count, one-byte match
  // followed by an ignored trailing word. Register reset values are
  // covered since type 178 matches without any config write.
  // ---------------------------------------------------------------
  localparam extract_result_t NO_RESULT = '0;
  directed_row_t directed_rows [23] = '{
    // single byte frame: truncated at once
    '{8'hA5, 1'b1, ROW_RESULT, '{8'h00, ST_TRUNCATED, 1'b1}},
    // header of all ones except item count 0
    '{8'hFF, 1'b0, ROW_QUIET,  NO_RESULT},
    '{8'hFF, 1'b0, ROW_QUIET,  NO_RESULT},
    '{8'hFF, 1'b0, ROW_QUIET,  NO_RESULT},
    '{8'hFF, 1'b0, ROW_QUIET,  NO_RESULT},
    '{8'hFF, 1'b0, ROW_QUIET,  NO_RESULT},
    '{8'hFF, 1'b0, ROW_QUIET,  NO_RESULT},
    '{8'h00, 1'b0, ROW_QUIET,  NO_RESULT},
    '{8'h00, 1'b1, ROW_RESULT, '{8'h00, ST_NOT_FOUND, 1'b1}},
    // all-zero header with one item
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h01, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    // item type 178 (reset value), length 1
    '{8'hB2, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h01, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
    '{8'hFF, 1'b0, ROW_RESULT, '{8'hFF, ST_DATA, 1'b1}},
    // trailing word after the final result: ignored, even with frame end
    '{8'h00, 1'b1, ROW_QUIET,  NO_RESULT}
  };

  // ---------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------
  logic [7:0] frame_q[$];

  // Offers one word after a random gap and records its expectation once
  // it is taken. in_tvalid gets at most one assignment per time step.
  task automatic send_byte(input logic [7:0] b, input logic e,
                           input row_check_e check, input extract_result_t want);
    int              gap;
    extract_result_t r;
    bit              hit;
    gap = burst_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= e;
    do @(posedge clk); while (!in_tready);
    hit = parse_byte(b, e, r);
    case (check)
      ROW_MODEL:  if (hit) pending_results.push_back(r);
      ROW_RESULT: pending_results.push_back(want);
      default: ;
    endcase
  endtask

  // Builds one frame into frame_q. Most frames are well formed with random
  // content; a few are pure noise and some get cut short.
  task automatic build_frame();
    int          roll;
    int          n_items;
    int          len;
    int          i;
    logic [15:0] count;
    logic [15:0] typ;
    frame_q.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
      return;
    end
    repeat (6) frame_q.push_back(8'($urandom));   // handle and timeout
    roll = $urandom_range(0, 99);
    if (roll < 8)       count = 16'd0;
    else if (roll < 14) count = 16'($urandom);     // huge count, frame ends first
    else                count = 16'($urandom_range(1, 4));
    frame_q.push_back(count[7:0]);
    frame_q.push_back(count[15:8]);
    n_items = (count > 16'd6) ? 6 : int'(count);
    for (i = 0; i < n_items; i++) begin
      typ  = ($urandom_range(0, 99) < 35) ? want_type : 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 15)      len = 0;
      else if (roll < 30) len = $urandom_range(1, 2);
      else if (roll < 80) len = $urandom_range(3, 12);
      else if (roll < 95) len = $urandom_range(13, 40);
      else                len = $urandom_range(0, 65535);  // data runs out: truncation
      frame_q.push_back(typ[7:0]);
      frame_q.push_back(typ[15:8]);
      frame_q.push_back(8'(len));
      frame_q.push_back(8'(len >> 8));
      repeat ((len > 40) ? $urandom_range(0, 40) : len) frame_q.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));  // trailing junk
    if ($urandom_range(0, 99) < 12)
      frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic apply_settings(input logic [15:0] typ, input logic strip);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WANTED_TYPE;
    cfg_data  <= typ;
    do @(posedge clk); while (!cfg_ready);
    want_type = typ;
    cfg_index <= CFG_STRIP_SEQ;
    cfg_data  <= {15'd0, strip};
    do @(posedge clk); while (!cfg_ready);
    strip_seq = strip;
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected word, then let the pipeline empty out; a
  // trailing word that makes no result may still be in flight.
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          p;
    int          i;
    int          sent;
    logic [15:0] typ;
    logic        strip;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WANTED_TYPE;
    cfg_data  = '0;
    errors    = 0;
    burst_in  = 1'b0;
    want_type = WANTED_TYPE_RST;
    strip_seq = 1'b0;
    clear_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_byte(directed_rows[k].frame_byte, directed_rows[k].frame_end,
                directed_rows[k].check, directed_rows[k].want);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1:       begin typ = 16'h0000; strip = 1'b1; end
          2:       begin typ = 16'hFFFF; strip = 1'b0; end
          3:       begin typ = 16'hFFFF; strip = 1'b1; end
          default: begin typ = 16'($urandom); strip = 1'($urandom); end
        endcase
        apply_settings(typ, strip);
      end
      burst_in = (p % 3 == 1);   // some phases run back to back
      sent = 0;
      while (sent < PHASE_WORDS) begin
        build_frame();
        for (i = 0; i < frame_q.size(); i++)
          send_byte(frame_q[i], i == frame_q.size() - 1, ROW_MODEL, NO_RESULT);
        sent += frame_q.size();
      end
      in_tvalid <= 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("tb_cpf_item_extractor OK");
    end else begin
      $display("tb_cpf_item_extractor NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------
  // Receiver side: random stalls, one long hold-off so the result
  // buffer fills and in_tready drops, and stretches with no stalls.
  // ---------------------------------------------------------------
  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  initial begin
    int              stall;
    extract_result_t want;
    out_tready = 1'b0;
    n_checked  = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (n_checked == HOLD_AT)              stall = HOLD_CYCLES;
      else if ((n_checked / 100) % 4 == 3)   stall = 0;
      else                                   stall = $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none actual data %0h status %0d last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("payload", want.payload, out_tdata);
        check_field("status", 8'(want.status), 8'(out_tuser));
        check_field("last", 8'(want.last), 8'(out_tlast));
      end
      n_checked++;
    end
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d words still expected", $time, pending_results.size());
    $display("tb_cpf_item_extractor NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// ===== cpf_item_extractor.f =====
rtl/cpf_pkg.sv
rtl/cpf_parse.sv
rtl/cpf_res_buf.sv
rtl/cpf_item_extractor.sv
bench/tb_cpf_item_extractor.sv
